@@ src/iwcf_pkg.sv @@
// Shared types and constants for the Wolff cluster flip block.
`timescale 1ns / 1ps
package iwcf_pkg;

	localparam int IN_COORD_W = 6;
	localparam int SIZE_W = 13;
	localparam int THR_W = 16;
	localparam int RNG_W = 32;
	localparam int CFG_DATA_W = 32;
	localparam int CFG_INDEX_W = 1;

	localparam logic [CFG_INDEX_W-1:0] CFG_ACCEPT_THRESHOLD = 1'b0;
	localparam logic [CFG_INDEX_W-1:0] CFG_RNG_SEED = 1'b1;

	localparam logic [RNG_W-1:0] RNG_RESET = 32'd1;

	typedef enum logic [1:0] {
		OP_WRITE = 2'd0,
		OP_READ  = 2'd1,
		OP_FLIP  = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		DIR_XP = 2'd0,
		DIR_XM = 2'd1,
		DIR_YP = 2'd2,
		DIR_YM = 2'd3
	} dir_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_REDUCE,
		ST_EXEC,
		ST_RD_WAIT,
		ST_POP,
		ST_POP_WAIT,
		ST_NB_RD,
		ST_NB_CHK,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic load;
		logic step;
	} rng_ctrl_t;

endpackage

@@ src/iwcf_rng.sv @@
// Xorshift random number generator with seed load and one draw per step.
`timescale 1ns / 1ps
module iwcf_rng import iwcf_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  rng_ctrl_t         ctrl,
	input  logic [RNG_W-1:0]  seed,
	output logic [THR_W-1:0]  draw
);

	logic [RNG_W-1:0] state_q;
	logic [RNG_W-1:0] v1;
	logic [RNG_W-1:0] v2;
	logic [RNG_W-1:0] v3;

	always_comb begin
		v1 = state_q ^ (state_q << 13);
		v2 = v1 ^ (v1 >> 17);
		v3 = v2 ^ (v2 << 5);
	end

	assign draw = v3[RNG_W-1 -: THR_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= RNG_RESET;
		end else if (ctrl.load) begin
			state_q <= (seed == '0) ? RNG_RESET : seed;
		end else if (ctrl.step) begin
			state_q <= v3;
		end
	end

endmodule

@@ src/ising_wolff_cluster_flip_top.sv @@
// Top level of the Wolff single-cluster flip engine for a periodic Ising lattice.
`timescale 1ns / 1ps
// After reset the block sweeps the spin memory to all minus-one spins, one site per cycle, over
// all 2**(2*ceil(log2(LATTICE_SIDE))) addresses (4096 at the default side), and holds busy high
// meanwhile; configuration writes are taken at any time. A word is taken when start is high
// and busy is low, and its result appears on done for one cycle with no way to hold it off.
// A write passes through the reduce, execute and finish states, and a read adds a read-wait
// state before finish; reduce repeats once for each side length subtracted from a coordinate
// beyond the lattice. A flip costs each cluster site a stack read and four neighbor tests of
// a read state and a check state, set by the single spin read port and its registered data.
module ising_wolff_cluster_flip_top import iwcf_pkg::*; #(
	parameter int LATTICE_SIDE = 64
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_wdata,
	input  logic                   start,
	output logic                   busy,
	input  logic [1:0]             operation,
	input  logic [IN_COORD_W-1:0]  site_x,
	input  logic [IN_COORD_W-1:0]  site_y,
	input  logic                   spin_in,
	output logic                   done,
	output logic                   spin_out,
	output logic [SIZE_W-1:0]      cluster_size
);

	localparam int CW = $clog2(LATTICE_SIDE);
	localparam int AW = 2 * CW;
	localparam int MEM_DEPTH = 1 << AW;
	localparam int SITE_COUNT = LATTICE_SIDE * LATTICE_SIDE;
	localparam int NW = $clog2(SITE_COUNT + 1);
	localparam int RW = (IN_COORD_W > CW + 1) ? IN_COORD_W : CW + 1;
	localparam logic [RW-1:0] SIDE_R = RW'(LATTICE_SIDE);
	localparam logic [CW-1:0] SIDE_M1 = CW'(LATTICE_SIDE - 1);

	state_t state_q;
	state_t state_d;

	logic [AW-1:0]    clr_q;
	op_t              op_q;
	logic [RW-1:0]    x_q;
	logic [RW-1:0]    y_q;
	logic             spin_in_q;
	logic             seed_spin_q;
	logic [NW-1:0]    sp_q;
	logic [NW-1:0]    cnt_q;
	logic [CW-1:0]    cur_x_q;
	logic [CW-1:0]    cur_y_q;
	dir_t             k_q;
	logic [AW-1:0]    nb_q;
	logic [THR_W-1:0] thr_q;
	logic             res_spin_q;
	logic [SIZE_W-1:0] res_size_q;

	logic             spin_mem [MEM_DEPTH];
	logic             spin_rd_q;
	logic [AW-1:0]    stk_mem [MEM_DEPTH];
	logic [AW-1:0]    stk_rd_q;

	logic             spin_we;
	logic [AW-1:0]    spin_waddr;
	logic             spin_wdata;
	logic [AW-1:0]    spin_raddr;
	logic             stk_we;
	logic [AW-1:0]    stk_waddr;
	logic [AW-1:0]    stk_wdata;
	logic [AW-1:0]    stk_raddr;

	logic             accept;
	logic             x_big;
	logic             y_big;
	logic [RW-1:0]    red_diff;
	logic [AW-1:0]    site_addr;
	logic [CW-1:0]    nx;
	logic [CW-1:0]    ny;
	logic [AW-1:0]    nb_addr;
	logic             aligned;
	logic             bond;
	logic [THR_W-1:0] draw;
	rng_ctrl_t        rng_ctrl;

	assign accept = start && !busy;
	assign x_big = (x_q >= SIDE_R);
	assign y_big = (y_q >= SIDE_R);
	assign red_diff = (x_big ? x_q : y_q) - SIDE_R;
	assign site_addr = {x_q[CW-1:0], y_q[CW-1:0]};
	assign aligned = (spin_rd_q == seed_spin_q);
	assign bond = (draw <= thr_q);

	always_comb begin
		nx = cur_x_q;
		ny = cur_y_q;
		unique case (k_q)
			DIR_XP: nx = (cur_x_q == SIDE_M1) ? '0 : cur_x_q + CW'(1);
			DIR_XM: nx = (cur_x_q == '0) ? SIDE_M1 : cur_x_q - CW'(1);
			DIR_YP: ny = (cur_y_q == SIDE_M1) ? '0 : cur_y_q + CW'(1);
			DIR_YM: ny = (cur_y_q == '0) ? SIDE_M1 : cur_y_q - CW'(1);
			default: ;
		endcase
		nb_addr = {nx, ny};
	end

	iwcf_rng u_rng (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (rng_ctrl),
		.seed   (cfg_wdata[RNG_W-1:0]),
		.draw   (draw)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (&clr_q) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (start) state_d = ST_REDUCE;
			end
			ST_REDUCE: begin
				if (!x_big && !y_big) state_d = ST_EXEC;
			end
			ST_EXEC: begin
				if (op_q == OP_READ || op_q == OP_FLIP) state_d = ST_RD_WAIT;
				else state_d = ST_FINISH;
			end
			ST_RD_WAIT: begin
				if (op_q == OP_FLIP) state_d = ST_POP;
				else state_d = ST_FINISH;
			end
			ST_POP: begin
				if (sp_q == '0) state_d = ST_FINISH;
				else state_d = ST_POP_WAIT;
			end
			ST_POP_WAIT: state_d = ST_NB_RD;
			ST_NB_RD: state_d = ST_NB_CHK;
			ST_NB_CHK: begin
				if (k_q == DIR_YM) state_d = ST_POP;
				else state_d = ST_NB_RD;
			end
			ST_FINISH: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		busy = (state_q != ST_IDLE);
		done = (state_q == ST_FINISH);
		spin_we = 1'b0;
		spin_waddr = site_addr;
		spin_wdata = spin_in_q;
		spin_raddr = site_addr;
		stk_we = 1'b0;
		stk_waddr = sp_q[AW-1:0];
		stk_wdata = nb_q;
		stk_raddr = AW'(sp_q - NW'(1));
		rng_ctrl.load = cfg_we && (cfg_index == CFG_RNG_SEED);
		rng_ctrl.step = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				spin_we = 1'b1;
				spin_waddr = clr_q;
				spin_wdata = 1'b0;
			end
			ST_EXEC: begin
				spin_we = (op_q == OP_WRITE);
			end
			ST_RD_WAIT: begin
				if (op_q == OP_FLIP) begin
					spin_we = 1'b1;
					spin_wdata = ~spin_rd_q;
					stk_we = 1'b1;
					stk_waddr = '0;
					stk_wdata = site_addr;
				end
			end
			ST_NB_RD: begin
				spin_raddr = nb_addr;
			end
			ST_NB_CHK: begin
				spin_waddr = nb_q;
				spin_wdata = ~seed_spin_q;
				if (aligned) begin
					rng_ctrl.step = 1'b1;
					spin_we = bond;
					stk_we = bond;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (spin_we) spin_mem[spin_waddr] <= spin_wdata;
		spin_rd_q <= spin_mem[spin_raddr];
	end

	always_ff @(posedge clk) begin
		if (stk_we) stk_mem[stk_waddr] <= stk_wdata;
		stk_rd_q <= stk_mem[stk_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q <= '0;
			sp_q <= '0;
			cnt_q <= '0;
			thr_q <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_we && cfg_index == CFG_ACCEPT_THRESHOLD) thr_q <= cfg_wdata[THR_W-1:0];
			unique case (state_q)
				ST_CLEAR: clr_q <= clr_q + AW'(1);
				ST_RD_WAIT: begin
					if (op_q == OP_FLIP) begin
						sp_q <= NW'(1);
						cnt_q <= NW'(1);
					end
				end
				ST_POP: begin
					if (sp_q != '0) sp_q <= sp_q - NW'(1);
				end
				ST_NB_CHK: begin
					if (aligned && bond) begin
						sp_q <= sp_q + NW'(1);
						cnt_q <= cnt_q + NW'(1);
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					op_q <= op_t'(operation);
					x_q <= RW'(site_x);
					y_q <= RW'(site_y);
					spin_in_q <= spin_in;
				end
			end
			ST_REDUCE: begin
				if (x_big) x_q <= red_diff;
				else if (y_big) y_q <= red_diff;
			end
			ST_EXEC: begin
				res_spin_q <= 1'b0;
				res_size_q <= '0;
			end
			ST_RD_WAIT: begin
				res_spin_q <= spin_rd_q;
				seed_spin_q <= spin_rd_q;
			end
			ST_POP: begin
				if (sp_q == '0) res_size_q <= SIZE_W'(cnt_q);
			end
			ST_POP_WAIT: begin
				cur_x_q <= stk_rd_q[AW-1:CW];
				cur_y_q <= stk_rd_q[CW-1:0];
				k_q <= DIR_XP;
			end
			ST_NB_RD: nb_q <= nb_addr;
			ST_NB_CHK: k_q <= dir_t'(k_q + 2'd1);
			default: ;
		endcase
	end

	assign spin_out = res_spin_q;
	assign cluster_size = res_size_q;

	a_stack_bound: assert property (@(posedge clk) disable iff (!arst_n)
		sp_q <= NW'(SITE_COUNT))
		else $error("Site stack pointer passed the lattice size.");

	a_count_covers_stack: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q >= sp_q)
		else $error("Flip count fell below the number of stacked sites.");

	a_size_only_flip: assert property (@(posedge clk) disable iff (!arst_n)
		(done && op_q != OP_FLIP) |-> (cluster_size == '0))
		else $error("Nonzero cluster size on a word that was not a flip.");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy)
		else $error("Block not busy after taking a word.");

endmodule

@@ dv/ising_wolff_cluster_flip_checker.sv @@
// Checker that predicts each result word of the Wolff cluster flip block and compares it.
`timescale 1ns / 1ps
module ising_wolff_cluster_flip_checker import iwcf_pkg::*; #(
	parameter int LATTICE_SIDE = 64
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_wdata,
	input  logic                   start,
	input  logic                   busy,
	input  logic [1:0]             operation,
	input  logic [IN_COORD_W-1:0]  site_x,
	input  logic [IN_COORD_W-1:0]  site_y,
	input  logic                   spin_in,
	input  logic                   done,
	input  logic                   spin_out,
	input  logic [SIZE_W-1:0]      cluster_size,
	output int                     mismatches,
	output int                     pending
);

	localparam int SITES = LATTICE_SIDE * LATTICE_SIDE;

	typedef struct packed {
		logic              spin;
		logic [SIZE_W-1:0] size;
	} outcome_t;

	bit               lattice [SITES];
	int               grow_stack [SITES];
	logic [THR_W-1:0] bond_thr;
	logic [RNG_W-1:0] rng_q;
	outcome_t         outcome_q [$];

	// Advances the xorshift state once and returns its upper half.
	function automatic logic [THR_W-1:0] draw_bond();
		logic [RNG_W-1:0] v;
		v = rng_q;
		v ^= v << 13;
		v ^= v >> 17;
		v ^= v << 5;
		rng_q = v;
		return v[RNG_W-1:RNG_W-THR_W];
	endfunction

	function automatic int flip_cluster(input int seed, input bit seed_spin);
		int   flipped;
		int   depth;
		int   cur;
		int   row;
		int   col;
		int   nb;
		int   k;
		dir_t dir;
		flipped = 1;
		lattice[seed] = !seed_spin;
		grow_stack[0] = seed;
		depth = 1;
		while (depth > 0) begin
			depth--;
			cur = grow_stack[depth];
			for (k = 0; k < 4; k++) begin
				row = cur / LATTICE_SIDE;
				col = cur % LATTICE_SIDE;
				dir = dir_t'(k);
				case (dir)
					DIR_XP: row = (row + 1) % LATTICE_SIDE;
					DIR_XM: row = (row + LATTICE_SIDE - 1) % LATTICE_SIDE;
					DIR_YP: col = (col + 1) % LATTICE_SIDE;
					default: col = (col + LATTICE_SIDE - 1) % LATTICE_SIDE;
				endcase
				nb = row * LATTICE_SIDE + col;
				if (lattice[nb] == seed_spin) begin
					if (draw_bond() <= bond_thr && depth < SITES) begin
						lattice[nb] = !seed_spin;
						grow_stack[depth] = nb;
						depth++;
						flipped++;
					end
				end
			end
		end
		return flipped;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		int       site;
		outcome_t want;
		outcome_t got;
		if (!arst_n) begin
			lattice = '{default: 1'b0};
			bond_thr = '0;
			rng_q = RNG_RESET;
			outcome_q.delete();
			mismatches = 0;
		end else begin
			if (done) begin
				got = '{spin: spin_out, size: cluster_size};
				if (outcome_q.size() == 0) begin
					if (mismatches < 10)
						$display("%0t: unexpected word: spin_out %0d cluster_size %0d",
							$realtime, got.spin, got.size);
					mismatches++;
				end else begin
					want = outcome_q.pop_front();
					if (got !== want) begin
						if (mismatches < 10)
							$display({"%0t: word mismatch: expected spin_out %0d cluster_size %0d,",
								" got spin_out %0d cluster_size %0d"}, $realtime,
								want.spin, want.size, got.spin, got.size);
						mismatches++;
					end
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					CFG_ACCEPT_THRESHOLD: bond_thr = cfg_wdata[THR_W-1:0];
					CFG_RNG_SEED: rng_q = (cfg_wdata[RNG_W-1:0] == '0) ? RNG_RESET :
						cfg_wdata[RNG_W-1:0];
					default: ;
				endcase
			end
			if (start && !busy) begin
				site = (int'(site_x) % LATTICE_SIDE) * LATTICE_SIDE + int'(site_y) % LATTICE_SIDE;
				want = '0;
				case (operation)
					OP_WRITE: lattice[site] = spin_in;
					OP_READ: want.spin = lattice[site];
					OP_FLIP: begin
						want.spin = lattice[site];
						want.size = SIZE_W'(flip_cluster(site, lattice[site]));
					end
					default: ;
				endcase
				outcome_q = {outcome_q, want};
			end
		end
		pending = outcome_q.size();
	end

endmodule

@@ dv/ising_wolff_cluster_flip_top_tb.sv @@
// Testbench top that drives words and register writes into the Wolff cluster flip block.
`timescale 1ns / 1ps
module ising_wolff_cluster_flip_top_tb;
	import iwcf_pkg::*;

	localparam int LATTICE_SIDE = 64;
	localparam logic [1:0] OP_UNUSED = 2'd3;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   cfg_we = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = CFG_ACCEPT_THRESHOLD;
	logic [CFG_DATA_W-1:0]  cfg_wdata = '0;
	logic                   start = 1'b0;
	logic                   busy;
	logic [1:0]             operation = OP_WRITE;
	logic [IN_COORD_W-1:0]  site_x = '0;
	logic [IN_COORD_W-1:0]  site_y = '0;
	logic                   spin_in = 1'b0;
	logic                   done;
	logic                   spin_out;
	logic [SIZE_W-1:0]      cluster_size;
	int                     mismatches;
	int                     pending;
	bit                     gaps_on = 1'b1;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	ising_wolff_cluster_flip_top #(
		.LATTICE_SIDE(LATTICE_SIDE)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.start(start),
		.busy(busy),
		.operation(operation),
		.site_x(site_x),
		.site_y(site_y),
		.spin_in(spin_in),
		.done(done),
		.spin_out(spin_out),
		.cluster_size(cluster_size)
	);

	ising_wolff_cluster_flip_checker #(
		.LATTICE_SIDE(LATTICE_SIDE)
	) i_checker (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.start(start),
		.busy(busy),
		.operation(operation),
		.site_x(site_x),
		.site_y(site_y),
		.spin_in(spin_in),
		.done(done),
		.spin_out(spin_out),
		.cluster_size(cluster_size),
		.mismatches(mismatches),
		.pending(pending)
	);

	task automatic set_bond(input logic [THR_W-1:0] thr, input logic [RNG_W-1:0] seed);
		cfg_we <= 1'b1;
		cfg_index <= CFG_ACCEPT_THRESHOLD;
		cfg_wdata <= CFG_DATA_W'(thr);
		@(posedge clk);
		cfg_index <= CFG_RNG_SEED;
		cfg_wdata <= CFG_DATA_W'(seed);
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// Start is left high after a word is taken; while gaps_on is set it drops on 15 percent of attempts.
	task automatic send_word(input logic [1:0] op, input logic [IN_COORD_W-1:0] x,
		input logic [IN_COORD_W-1:0] y, input logic s);
		bit taken;
		operation <= op;
		site_x <= x;
		site_y <= y;
		spin_in <= s;
		taken = 1'b0;
		while (!taken) begin
			start <= !(gaps_on && $urandom_range(0, 99) < 15);
			@(posedge clk);
			taken = start && !busy;
		end
	endtask

	task automatic drain();
		start <= 1'b0;
		do @(negedge clk); while (pending != 0);
		repeat (8) @(posedge clk);
	endtask

	function automatic logic [IN_COORD_W-1:0] pick_coord();
		if ($urandom_range(0, 9) == 0)
			return $urandom_range(0, 1) ? IN_COORD_W'(LATTICE_SIDE - 1) : '0;
		return IN_COORD_W'($urandom_range(0, LATTICE_SIDE - 1));
	endfunction

	initial begin
		#250_000_000;
		$display("Mismatches found");
		$finish;
	end

	initial begin
		int               phase;
		int               r;
		logic [1:0]       op;
		logic [THR_W-1:0] thr;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		set_bond(16'h0000, 32'h0000_0000);
		send_word(OP_UNUSED, 6'd0, 6'd0, 1'b1);
		send_word(OP_READ, 6'd0, 6'd0, 1'b0);
		send_word(OP_WRITE, 6'd0, 6'd0, 1'b1);
		send_word(OP_WRITE, 6'd63, 6'd63, 1'b1);
		send_word(OP_WRITE, 6'd0, 6'd63, 1'b1);
		send_word(OP_WRITE, 6'd63, 6'd0, 1'b1);
		send_word(OP_READ, 6'd0, 6'd0, 1'b0);
		send_word(OP_READ, 6'd63, 6'd63, 1'b0);
		send_word(OP_FLIP, 6'd63, 6'd0, 1'b0);
		send_word(OP_FLIP, 6'd10, 6'd10, 1'b1);
		drain();
		// Every draw bonds now, so each flip floods its whole aligned region.
		set_bond(16'hFFFF, 32'hFFFF_FFFF);
		send_word(OP_FLIP, 6'd32, 6'd32, 1'b0);
		send_word(OP_READ, 6'd17, 6'd45, 1'b0);
		send_word(OP_UNUSED, 6'd63, 6'd63, 1'b1);
		send_word(OP_FLIP, 6'd0, 6'd0, 1'b1);
		send_word(OP_READ, 6'd63, 6'd0, 1'b1);
		for (phase = 0; phase < 4; phase++) begin
			drain();
			// Bond probabilities stay below the percolation point to keep clusters small.
			case (phase)
				0: thr = THR_W'($urandom_range(0, 16'h3000));
				1: thr = THR_W'($urandom_range(16'h3000, 16'h6000));
				2: thr = THR_W'($urandom_range(0, 16'h6000));
				default: thr = THR_W'($urandom_range(16'h1000, 16'h5000));
			endcase
			set_bond(thr, $urandom());
			gaps_on = (phase != 2);
			repeat (25) begin
				r = $urandom_range(0, 99);
				if (r < 30)
					op = OP_WRITE;
				else if (r < 55)
					op = OP_READ;
				else if (r < 95)
					op = OP_FLIP;
				else
					op = OP_UNUSED;
				send_word(op, pick_coord(), pick_coord(), 1'($urandom_range(0, 1)));
			end
		end
		drain();
		repeat (20) @(posedge clk);
		if (mismatches == 0 && pending == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
